FILE: sv/cqmtf_pkg.sv
// Shared constants for the move-to-front circular queue.
// No dependencies; imported by the top level and the checker.
package cqmtf_pkg;

	localparam int CMD_W = 3;

	typedef logic [CMD_W-1:0] cmd_t;

	// Command codes; codes above MOVE_BACK behave as PEEK.
	localparam cmd_t CMD_ENQ       = 3'd0;
	localparam cmd_t CMD_DEQ       = 3'd1;
	localparam cmd_t CMD_PEEK      = 3'd2;
	localparam cmd_t CMD_MOVE_FRNT = 3'd3;
	localparam cmd_t CMD_MOVE_BACK = 3'd4;

endpackage

FILE: sv/cqmtf_ram.sv
// Single-port entry store for the move-to-front queue.
// One read or one write per cycle, read data registered. No dependencies.
module cqmtf_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [IDX_W-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/cqmtf_slot.sv
// Shared slot/compare unit: maps a queue position to a storage slot
// (head plus position, wrapped at DEPTH) and compares stored data with the key.
// No dependencies.
module cqmtf_slot #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic [IDX_W-1:0] head,
	input  logic [CNT_W-1:0] pos,
	input  logic [WIDTH-1:0] key,
	input  logic [WIDTH-1:0] data,
	output logic [IDX_W-1:0] slot,
	output logic             match
);

	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;

	// head < DEPTH and pos <= DEPTH, so one subtract wraps the sum.
	assign sum     = SUM_W'(head) + SUM_W'(pos);
	assign wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
	assign slot    = wrapped[IDX_W-1:0];
	assign match   = (data == key);

endmodule

FILE: sv/circular_queue_move_to_front.sv
// Bounded circular queue of keys with move-to-front and move-to-back.
// Depends on cqmtf_pkg, cqmtf_ram and cqmtf_slot.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   req     | req_valid/req_ready  | cmd, key
//   rsp     | rsp_valid/rsp_ready  | value, value_valid, found, overflow,
//           |                      | occupancy, empty_res
//
// Sequencing: one command at a time through a small sequencer around one
// single-port RAM and one shared slot/compare unit. Move-to-front scans from
// the front, each entry a RAM read and then a compare; on a match it shifts
// the entries ahead of the key back by one slot (RAM read, then write) and
// writes the key at the front. A new command is taken only once the
// sequencer is back in idle.
// Reset: head, count, sequencer and response valid clear; the RAM holds no
// reset and only occupied slots are ever read.
// Stalls: a finished result sits in the response register while the next
// command is taken; the sequencer holds in its final step only if the
// previous result has still not been taken.
module circular_queue_move_to_front
	import cqmtf_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [CMD_W-1:0]               cmd,
	input  logic [KEY_WIDTH-1:0]           key,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [KEY_WIDTH-1:0]           value,
	output logic                           value_valid,
	output logic                           found,
	output logic                           overflow,
	output logic [$clog2(DEPTH+1)-1:0]     occupancy,
	output logic                           empty_res
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_KEY_WR,
		ST_BACK_CMP,
		ST_FRONT_CMP,
		ST_ADV,
		ST_FRONT_RD,
		ST_FRONT_WAIT,
		ST_DONE
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       pos_q;
	logic                   found_q;
	logic                   ovf_q;
	logic [KEY_WIDTH-1:0]   val_q;
	logic                   vvalid_q;

	// response register
	logic                   rsp_valid_q;
	logic [KEY_WIDTH-1:0]   value_q;
	logic                   value_valid_q;
	logic                   found_out_q;
	logic                   overflow_q;
	logic [CNT_W-1:0]       occupancy_q;
	logic                   empty_q;

	// shared unit and RAM hookup
	logic [CNT_W-1:0]       pos_sel;
	logic [IDX_W-1:0]       slot;
	logic                   match;
	logic                   ram_we;
	logic                   ram_re;
	logic [KEY_WIDTH-1:0]   ram_wdata;
	logic [KEY_WIDTH-1:0]   ram_rdata;
	logic                   rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	cqmtf_slot #(
		.DEPTH(DEPTH),
		.WIDTH(KEY_WIDTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_slot (
		.head (head_q),
		.pos  (pos_sel),
		.key  (key_q),
		.data (ram_rdata),
		.slot (slot),
		.match(match)
	);

	cqmtf_ram #(
		.DEPTH(DEPTH),
		.WIDTH(KEY_WIDTH),
		.IDX_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (slot),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Position select and RAM strobes for the current step.
	always_comb begin
		pos_sel   = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = key_q;
		unique case (state_q)
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_ENQ: begin
						// append at the back unless full
						pos_sel = count_q;
						ram_we  = (count_q != FULL_CNT);
					end
					CMD_DEQ: begin
						ram_re = (count_q != '0);
					end
					CMD_MOVE_BACK: begin
						// fetch the back entry first
						pos_sel = count_q - ONE_CNT;
						ram_re  = (count_q != '0);
					end
					default: begin
					end
				endcase
			end
			ST_DEQ_WAIT: begin
				pos_sel = ONE_CNT;
			end
			ST_SCAN_RD: begin
				pos_sel = pos_q;
				ram_re  = (pos_q != count_q);
			end
			ST_SHIFT_RD: begin
				pos_sel = pos_q - ONE_CNT;
				ram_re  = 1'b1;
			end
			ST_SHIFT_WR: begin
				pos_sel   = pos_q;
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_KEY_WR: begin
				ram_we = 1'b1;
			end
			ST_BACK_CMP: begin
				ram_re = !match;
			end
			ST_FRONT_CMP: begin
				// rotate: copy the front entry into the slot after the back
				pos_sel   = count_q;
				ram_we    = match;
				ram_wdata = ram_rdata;
			end
			ST_ADV: begin
				pos_sel = ONE_CNT;
			end
			ST_FRONT_RD: begin
				ram_re = (count_q != '0);
			end
			default: begin
			end
		endcase
	end

	// Sequencer, queue state and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
			cmd_q         <= CMD_PEEK;
			key_q         <= '0;
			pos_q         <= '0;
			found_q       <= 1'b0;
			ovf_q         <= 1'b0;
			val_q         <= '0;
			vvalid_q      <= 1'b0;
			value_q       <= '0;
			value_valid_q <= 1'b0;
			found_out_q   <= 1'b0;
			overflow_q    <= 1'b0;
			occupancy_q   <= '0;
			empty_q       <= 1'b1;
		end else begin
			// raise valid as a finished result loads, drop it once taken
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q   <= cmd;
						key_q   <= key;
						pos_q   <= '0;
						found_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_ENQ: begin
							if (count_q == FULL_CNT) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + ONE_CNT;
							end
							state_q <= ST_FRONT_RD;
						end
						CMD_DEQ: begin
							state_q <= (count_q != '0) ? ST_DEQ_WAIT : ST_FRONT_RD;
						end
						CMD_MOVE_FRNT: begin
							state_q <= ST_SCAN_RD;
						end
						CMD_MOVE_BACK: begin
							state_q <= (count_q != '0) ? ST_BACK_CMP : ST_FRONT_RD;
						end
						default: begin
							state_q <= ST_FRONT_RD;
						end
					endcase
				end
				ST_DEQ_WAIT: begin
					// report the removed entry, advance head
					val_q    <= ram_rdata;
					vvalid_q <= 1'b1;
					head_q   <= slot;
					count_q  <= count_q - ONE_CNT;
					state_q  <= ST_DONE;
				end
				ST_SCAN_RD: begin
					state_q <= (pos_q == count_q) ? ST_FRONT_RD : ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						state_q <= (pos_q == '0) ? ST_FRONT_RD : ST_SHIFT_RD;
					end else begin
						pos_q   <= pos_q + ONE_CNT;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					pos_q   <= pos_q - ONE_CNT;
					state_q <= (pos_q == ONE_CNT) ? ST_KEY_WR : ST_SHIFT_RD;
				end
				ST_KEY_WR: begin
					state_q <= ST_FRONT_RD;
				end
				ST_BACK_CMP: begin
					if (match) begin
						// key already at the back
						found_q <= 1'b1;
						state_q <= ST_FRONT_RD;
					end else begin
						state_q <= ST_FRONT_CMP;
					end
				end
				ST_FRONT_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						state_q <= ST_ADV;
					end else begin
						state_q <= ST_FRONT_RD;
					end
				end
				ST_ADV: begin
					head_q  <= slot;
					state_q <= ST_FRONT_RD;
				end
				ST_FRONT_RD: begin
					if (count_q == '0) begin
						val_q    <= '0;
						vvalid_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_FRONT_WAIT;
					end
				end
				ST_FRONT_WAIT: begin
					val_q    <= ram_rdata;
					vvalid_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the response register is free
					if (rsp_free) begin
						value_q       <= val_q;
						value_valid_q <= vvalid_q;
						found_out_q   <= found_q;
						overflow_q    <= ovf_q;
						occupancy_q   <= count_q;
						empty_q       <= (count_q == '0);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign value       = value_q;
	assign value_valid = value_valid_q;
	assign found       = found_out_q;
	assign overflow    = overflow_q;
	assign occupancy   = occupancy_q;
	assign empty_res   = empty_q;

endmodule

FILE: sv/cqmtf_checker.sv
// Port-level checks for the move-to-front queue, bound to the top level.
// Depends on circular_queue_move_to_front and cqmtf_pkg.
module cqmtf_checker
	import cqmtf_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic [CMD_W-1:0]           cmd,
	input logic [KEY_WIDTH-1:0]       key,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [KEY_WIDTH-1:0]       value,
	input logic                       value_valid,
	input logic                       found,
	input logic                       overflow,
	input logic [$clog2(DEPTH+1)-1:0] occupancy,
	input logic                       empty_res
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// a waiting command beat holds its payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(cmd) && $stable(key))
		else $error("command beat changed while waiting");

	// a dropped enqueue only happens on a full queue
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> (occupancy == CNT_W'(DEPTH)) && !found)
		else $error("overflow reported on a queue that is not full");

	// empty flag tracks the count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (empty_res == (occupancy == '0)))
		else $error("empty_res disagrees with occupancy");

	// a non-empty queue always reports a valid value; no item means zero value
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (empty_res || value_valid) && (value_valid || (value == '0)))
		else $error("value/value_valid inconsistent with queue state");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value) && $stable(occupancy))
		else $error("response changed while stalled");

endmodule

bind circular_queue_move_to_front cqmtf_checker #(
	.DEPTH(DEPTH),
	.KEY_WIDTH(KEY_WIDTH)
) u_cqmtf_checker (.*);
